### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared word types and codes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DATA_W-1:0] data_out;
        logic [LEN_W-1:0]        length;
    } res_word_t;

endpackage

### rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/positional_list_engine_unit.sv
// Steps: an error word is registered at accept; read runs FETCH then GRAB;
// insert runs UP once per element moved up, then PUT (PUT alone if none move);
// delete runs FETCH, GRAB and, if elements move down, DOWN per element and DRAIN.
// Throughput: one command at a time, bounded by the single RAM port pair.
// Reset: asynchronous, active low; clears length, sequencer and result valid.
// Element storage is not cleared; only entries below the length are read.
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed words with insert, delete and read at a position.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_UP    = 7'b0000010,
        S_PUT   = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_GRAB  = 7'b0010000,
        S_DOWN  = 7'b0100000,
        S_DRAIN = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [1:0]                op_reg, op_next;
    logic [AW-1:0]             tgt_reg, tgt_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [AW-1:0]             wr_addr_reg, wr_addr_next;
    logic                      wr_pend_reg, wr_pend_next;
    logic [DATA_W-1:0]         val_reg, val_next;
    logic                      res_valid_reg, res_valid_next;
    res_word_t                 res_reg, res_next;

    // RAM ports
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;

    // Position checks against the current length, in a width that holds both.
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic                      pos_zero;
    logic                      ins_ok;
    logic                      sel_ok;
    logic                      is_full;
    logic [AW-1:0]             pos_idx;
    logic [AW-1:0]             last_idx;
    logic                      accept;

    assign pos_ext  = CMP_W'(cmd.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_zero = (cmd.position == '0);
    assign ins_ok   = !pos_zero && (pos_ext <= cnt_ext + CMP_W'(1));
    assign sel_ok   = !pos_zero && (pos_ext <= cnt_ext);
    assign is_full  = (cnt_ext == CMP_W'(DEPTH));
    assign pos_idx  = AW'(pos_ext - CMP_W'(1));
    assign last_idx = AW'(count_reg - CNT_W'(1));

    // Take a new command only in idle, with the result register free or
    // draining in this same cycle.
    assign cmd_stall = !((state_reg == S_IDLE) && (!res_valid_reg || !res_stall));
    assign accept    = cmd_valid && !cmd_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // A pending shift write always wins the write port; the inserted value
    // goes in once the last moved element has landed.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        if (wr_pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            ram_we    = 1'b1;
            ram_waddr = tgt_reg;
            ram_wdata = val_reg;
        end
    end

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = tgt_reg;
        if ((state_reg == S_UP) || (state_reg == S_DOWN))
        begin
            ram_re    = 1'b1;
            ram_raddr = ptr_reg;
        end
        else if (state_reg == S_FETCH)
        begin
            ram_re = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        ptr_next       = ptr_reg;
        wr_addr_next   = wr_addr_reg;
        wr_pend_next   = 1'b0;
        val_next       = val_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = cmd.command;
                    tgt_next = pos_idx;
                    val_next = cmd.value;
                    // Default to an error word; overwritten on success paths.
                    res_next.status   = ST_RANGE;
                    res_next.data_out = '0;
                    res_next.length   = LEN_W'(count_reg);
                    unique case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (!ins_ok)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else if (is_full)
                            begin
                                res_next.status = ST_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else if (pos_ext == cnt_ext + CMP_W'(1))
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ptr_next   = last_idx;
                                state_next = S_UP;
                            end
                        end
                        CMD_DELETE, CMD_READ:
                        begin
                            if (sel_ok)
                            begin
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // Move element ptr up by one, walking down to the target.
            S_UP:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg + AW'(1);
                if (ptr_reg == tgt_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
            end

            S_PUT:
            begin
                if (!wr_pend_reg)
                begin
                    count_next        = count_reg + CNT_W'(1);
                    res_next.status   = ST_OK;
                    res_next.data_out = '0;
                    res_next.length   = LEN_W'(count_reg + CNT_W'(1));
                    res_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            S_FETCH:
            begin
                state_next = S_GRAB;
            end

            S_GRAB:
            begin
                val_next = ram_rdata;
                if (op_reg == CMD_READ)
                begin
                    res_next.status   = ST_OK;
                    res_next.data_out = ram_rdata;
                    res_next.length   = LEN_W'(count_reg);
                    res_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (tgt_reg == last_idx)
                begin
                    count_next        = count_reg - CNT_W'(1);
                    res_next.status   = ST_OK;
                    res_next.data_out = ram_rdata;
                    res_next.length   = LEN_W'(count_reg - CNT_W'(1));
                    res_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    ptr_next   = tgt_reg + AW'(1);
                    state_next = S_DOWN;
                end
            end

            // Move element ptr down by one, walking up to the last element.
            S_DOWN:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg - AW'(1);
                if (ptr_reg == last_idx)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            // Last shift write lands this cycle; report the removed word.
            S_DRAIN:
            begin
                count_next        = count_reg - CNT_W'(1);
                res_next.status   = ST_OK;
                res_next.data_out = val_reg;
                res_next.length   = LEN_W'(count_reg - CNT_W'(1));
                res_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wr_pend_reg   <= wr_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        tgt_reg     <= tgt_next;
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
    end

`ifndef SYNTHESIS
    a_pend_from_shift: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> ($past(state_reg) == S_UP || $past(state_reg) == S_DOWN))
        else $error("shift write pending outside a shift pass");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("length exceeds store depth");

    a_done_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_next == S_IDLE) |=> res_valid)
        else $error("command finished without a result word");

    a_no_idle_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_pend_reg)
        else $error("shift write still pending while idle");
`endif

endmodule

### bench/tb_positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine: a shadow list predicts
// every result word, directed words hit the empty and full edges, and random,
// mostly well-formed command streams run under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;
    import ple_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH            = 64;
    localparam int RANDOM_PER_PHASE = 370;
    localparam int SEGMENT_WORDS    = 40;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 100;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int REPORT_LIMIT     = 10;

    // Command code the engine does not define; it must answer with a range error.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res;

    // Pending command words, filled by the sequence below and drained by the driver.
    cmd_word_t cmd_queue[$];
    // Result words that the shadow list says must come back, oldest first.
    res_word_t expected_results[$];
    // Shadow copy of the ordered list, updated at each accepted command.
    logic signed [DATA_W-1:0] shadow_list[$];

    // Length the list will have once everything queued so far has run.
    int unsigned planned_len   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_token    = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;

    positional_list_engine_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the shadow list and return the word the engine owes.
    // Position is checked before fullness; any error leaves the list alone.
    function automatic res_word_t apply_to_shadow(cmd_word_t w);
        res_word_t   r;
        int unsigned p;
        r        = '0;
        r.status = ST_OK;
        p        = 32'(w.position);
        case (w.command)
            CMD_INSERT:
            begin
                if (p < 1 || p > shadow_list.size() + 1)
                    r.status = ST_RANGE;
                else if (shadow_list.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_list.insert(p - 1, w.value);
            end
            CMD_DELETE:
            begin
                if (p < 1 || p > shadow_list.size())
                    r.status = ST_RANGE;
                else
                begin
                    r.data_out = shadow_list[p - 1];
                    shadow_list.delete(p - 1);
                end
            end
            CMD_READ:
            begin
                if (p < 1 || p > shadow_list.size())
                    r.status = ST_RANGE;
                else
                    r.data_out = shadow_list[p - 1];
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.length = LEN_W'(shadow_list.size());
        return r;
    endfunction

    // Queue one command word and advance the planned length the same way the
    // engine will, so that later random positions can be aimed inside the list.
    task automatic queue_word(logic [1:0] op, int unsigned pos, logic [DATA_W-1:0] val);
        cmd_word_t w;
        w.command  = op;
        w.position = pos[POS_W-1:0];
        w.value    = val;
        cmd_queue.push_back(w);
        case (op)
            CMD_INSERT:
                if (pos >= 1 && pos <= planned_len + 1 && planned_len < DEPTH)
                    planned_len++;
            CMD_DELETE:
                if (pos >= 1 && pos <= planned_len)
                    planned_len--;
            default:
                ;
        endcase
    endtask

    // Mostly well-formed commands aimed at valid positions, with the ends of
    // the list favored; a few percent is noise over every code and position.
    task automatic queue_random_word(int unsigned insert_pct);
        int unsigned roll;
        int unsigned top;
        int unsigned pos;
        logic [1:0]  op;
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            op  = 2'($urandom_range(3));
            pos = $urandom_range(127);
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
                op = CMD_INSERT;
            else if (roll < insert_pct + (100 - insert_pct) * 2 / 3)
                op = CMD_DELETE;
            else
                op = CMD_READ;
            top = (op == CMD_INSERT) ? planned_len + 1 : planned_len;
            if (top == 0)
                top = 1;
            case ($urandom_range(4))
                0:       pos = 1;
                1:       pos = top;
                default: pos = $urandom_range(top, 1);
            endcase
        end
        queue_word(op, pos, $urandom());
    endtask

    // Hold until nothing is pending on either side of the engine.
    task automatic wait_until_idle();
        while (cmd_queue.size() != 0 || cmd_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Driver: advance to the next pending word once the current one is taken.
    // An accepted word is pushed through the shadow list at that same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
                expected_results.push_back(apply_to_shadow(cmd));
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_valid <= 1'b1;
                cmd       <= cmd_queue.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Receiver stall: random per the current phase, plus a long hold-off that
    // the sequence requests by bumping hold_token. During the hold the engine
    // keeps its finished word and has to push back on new commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (hold_token != hold_seen)
            begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            res_stall <= (hold_token != hold_seen) || (hold_left > 1)
                         || ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: compare each taken result word with the oldest prediction.
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result word with nothing expected: %p", res));
            else
            begin
                want = expected_results.pop_front();
                if (res.status !== want.status)
                    report_mismatch($sformatf("status expected %0d, got %0d",
                                              want.status, res.status));
                if (res.data_out !== want.data_out)
                    report_mismatch($sformatf("data_out expected %0d, got %0d",
                                              want.data_out, res.data_out));
                if (res.length !== want.length)
                    report_mismatch($sformatf("length expected %0d, got %0d",
                                              want.length, res.length));
            end
        end
    end

    // Watchdog: end the run if the engine hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("positional_list_engine_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned n;
        int unsigned insert_pct;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list: every read and delete is out of range, insert only at 1.
        queue_word(CMD_READ,   1, 32'd0);
        queue_word(CMD_DELETE, 1, 32'd0);
        queue_word(CMD_INSERT, 0, 32'h1234_5678);
        queue_word(CMD_INSERT, 2, 32'h1234_5678);
        queue_word(CMD_UNUSED, 1, 32'hFFFF_FFFF);
        // Build [-1, 0, min, max] through append, front and middle inserts.
        queue_word(CMD_INSERT, 1, 32'h8000_0000);
        queue_word(CMD_INSERT, 2, 32'h7FFF_FFFF);
        queue_word(CMD_INSERT, 1, 32'hFFFF_FFFF);
        queue_word(CMD_INSERT, 2, 32'h0000_0000);
        queue_word(CMD_READ,   4, 32'd0);
        queue_word(CMD_READ,   5, 32'd0);
        queue_word(CMD_READ, 127, 32'd0);
        queue_word(CMD_DELETE, 0, 32'd0);
        queue_word(CMD_READ,   1, 32'd0);
        // Remove the tail, the head, then the tail again.
        queue_word(CMD_DELETE, 4, 32'd0);
        queue_word(CMD_DELETE, 1, 32'd0);
        queue_word(CMD_DELETE, 2, 32'd0);

        // Fill to capacity with random values at random valid positions.
        while (planned_len < DEPTH)
            queue_word(CMD_INSERT, $urandom_range(planned_len + 1, 1), $urandom());

        // Full list: valid insert positions report full, bad ones report range.
        queue_word(CMD_INSERT, DEPTH + 1, 32'h5555_AAAA);
        queue_word(CMD_INSERT, 1,         32'hAAAA_5555);
        queue_word(CMD_INSERT, DEPTH + 2, 32'h0F0F_0F0F);
        queue_word(CMD_INSERT, 0,         32'hF0F0_F0F0);
        queue_word(CMD_READ,   DEPTH,     32'd0);
        queue_word(CMD_READ,   DEPTH + 1, 32'd0);
        queue_word(CMD_DELETE, DEPTH,     32'd0);
        queue_word(CMD_DELETE, 1,         32'd0);

        // Pause the sender until every answer is back.
        wait_until_idle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 49; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            // Long receiver hold-off while the sender keeps offering words.
            if (phase == 0)
                hold_token++;
            insert_pct = 50;
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Drift the insert share per segment so the list swings between
                // empty and full.
                if (n % SEGMENT_WORDS == 0)
                    case ($urandom_range(3))
                        0:       insert_pct = 15;
                        1:       insert_pct = 50;
                        2:       insert_pct = 65;
                        default: insert_pct = 92;
                    endcase
                queue_random_word(insert_pct);
            end
            wait_until_idle();
        end

        // Let any stray word surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("positional_list_engine_unit verification clean");
        else
            $display("positional_list_engine_unit verification failed");
        $finish;
    end

endmodule
